// ===== hdl/lrukv_pkg.sv =====
package lrukv_pkg;

  localparam int unsigned KeyW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned CfgW = 5;

  localparam logic [CfgW-1:0] CfgCapReset = 5'd16;

  typedef enum logic [0:0] {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

endpackage

// ===== hdl/lrukv_search.sv =====
module lrukv_search #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic [lrukv_pkg::KeyW-1:0] key_i,
  input  logic [CAPACITY-1:0]        valid_i,
  input  logic [lrukv_pkg::KeyW-1:0] keys_i [CAPACITY],
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ages_i [CAPACITY],
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] oldest_age_i,
  output logic                       hit_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_idx_o,
  output logic                       free_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] free_idx_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] old_idx_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // lowest index wins for match and free slot
  always_comb begin
    hit_o      = 1'b0;
    hit_idx_o  = '0;
    free_o     = 1'b0;
    free_idx_o = '0;
    old_idx_o  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid_i[i] && (keys_i[i] == key_i)) begin
        hit_o     = 1'b1;
        hit_idx_o = IdxW'(i);
      end
      if (!valid_i[i]) begin
        free_o     = 1'b1;
        free_idx_o = IdxW'(i);
      end
      // valid ages are distinct 0 .. count-1, so the oldest holds count-1
      if (valid_i[i] && (ages_i[i] == oldest_age_i)) begin
        old_idx_o = IdxW'(i);
      end
    end
  end

endmodule

// ===== hdl/lru_key_value_cache_core.sv =====
// channel  direction  handshake                payload
// in       input      in_valid_i / in_ready_o   opcode_i, lookup_key_i, store_value_i
// out      output     out_valid_o / out_ready_i hit_o, read_value_o
// cfg      input      cfg_we_i                  cfg_wdata_i (capacity in use)
//
// one beat per cycle sustained unless the result stalls; a beat goes through an input register
// and then a result register
// lookup, age update and entry write all happen as the beat moves between them
// reset clears entry valid bits, ages and count, and sets capacity in use to 16
// a stalled result holds; the input register then fills and in_ready_o drops
module lru_key_value_cache_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [0:0]                 opcode_i,
  input  logic [lrukv_pkg::KeyW-1:0] lookup_key_i,
  input  logic [lrukv_pkg::ValW-1:0] store_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [lrukv_pkg::ValW-1:0] read_value_o,
  input  logic                       cfg_we_i,
  input  logic [lrukv_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned LimW = (CntW > lrukv_pkg::CfgW) ? CntW : lrukv_pkg::CfgW;

  logic                       s1_valid_q;
  lrukv_pkg::op_e             op_q;
  logic [lrukv_pkg::KeyW-1:0] key_q;
  logic [lrukv_pkg::ValW-1:0] val_q;

  logic                       out_valid_q;
  logic                       hit_q;
  logic [lrukv_pkg::ValW-1:0] rdata_q;

  logic [lrukv_pkg::CfgW-1:0] cap_q;
  logic [CntW-1:0]            count_q, count_d;
  logic [CAPACITY-1:0]        valid_q, valid_d;
  logic [IdxW-1:0]            age_q [CAPACITY];
  logic [IdxW-1:0]            age_d [CAPACITY];
  logic [lrukv_pkg::KeyW-1:0] keys_q [CAPACITY];
  logic [lrukv_pkg::ValW-1:0] vals_q [CAPACITY];

  logic            step;
  logic [LimW-1:0] cap_ext, eff_cap;
  logic            has_room;
  logic [CntW-1:0] count_m1;
  logic            hit, free_found;
  logic [IdxW-1:0] hit_idx, free_idx, old_idx;
  logic            is_put, do_insert, do_evict, do_touch;
  logic [IdxW-1:0] tgt, slot;
  logic [IdxW-1:0] ref_age;

  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  always_comb begin
    cap_ext = LimW'(cap_q);
    priority if (cap_ext == '0) begin
      eff_cap = LimW'(1);
    end else if (cap_ext > LimW'(CAPACITY)) begin
      eff_cap = LimW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign has_room = LimW'(count_q) < eff_cap;
  assign count_m1 = count_q - CntW'(1);

  lrukv_search #(
    .CAPACITY(CAPACITY)
  ) u_search (
    .key_i       (key_q),
    .valid_i     (valid_q),
    .keys_i      (keys_q),
    .ages_i      (age_q),
    .oldest_age_i(count_m1[IdxW-1:0]),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .free_o      (free_found),
    .free_idx_o  (free_idx),
    .old_idx_o   (old_idx)
  );

  assign is_put    = (op_q == lrukv_pkg::OpPut);
  assign do_insert = is_put && !hit && has_room && free_found;
  assign do_evict  = is_put && !hit && !do_insert;
  assign do_touch  = hit || do_evict;
  assign tgt       = hit ? hit_idx : old_idx;
  assign slot      = do_insert ? free_idx : tgt;
  assign ref_age   = age_q[tgt];

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) begin
      age_d[i] = age_q[i];
    end
    if (step) begin
      if (do_touch) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (IdxW'(i) == tgt) begin
            age_d[i] = '0;
          end else if (valid_q[i] && (age_q[i] < ref_age)) begin
            age_d[i] = age_q[i] + IdxW'(1);
          end
        end
      end else if (do_insert) begin
        count_d = count_q + CntW'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (IdxW'(i) == free_idx) begin
            age_d[i]   = '0;
            valid_d[i] = 1'b1;
          end else if (valid_q[i]) begin
            age_d[i] = age_q[i] + IdxW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < CAPACITY; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (step && is_put && (IdxW'(i) == slot)) begin
        vals_q[i] <= val_q;
        if (!hit) begin
          keys_q[i] <= key_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lrukv_pkg::CfgCapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= lrukv_pkg::op_e'(opcode_i);
      key_q <= lookup_key_i;
      val_q <= store_value_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      hit_q   <= hit;
      rdata_q <= (!is_put && hit) ? vals_q[hit_idx] : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;

endmodule
